### rtl/core/lbbc_pkg.sv
// shared types and codes for the lru block buffer cache
`default_nettype none
package lbbc_pkg;

	typedef enum logic [1:0] {
		FUNC_GET       = 2'd0,
		FUNC_WRITE     = 2'd1,
		FUNC_RELEASE   = 2'd2,
		FUNC_DISK_DONE = 2'd3
	} func_t;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_BUF  = 2'd1;
	localparam logic [1:0] STATUS_REL_ERR = 2'd2;

	localparam logic [7:0] REFS_MAX = 8'd255;

	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  refs;
		logic        valid;
		logic        dirty;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_VICTIM,
		ST_SLOT_RD,
		ST_SLOT_UPD,
		ST_MRU,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic scan_read;
		logic scan_check;
		logic victim_commit;
		logic slot_read;
		logic slot_update;
		logic mru_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic new_get;
		logic new_oob;
		logic hit_now;
		logic last_rank;
		logic rel_zero;
		logic mru_end;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### rtl/core/lbbc_ctrl.sv
// sequencing state machine of the lru block buffer cache
`default_nettype none
module lbbc_ctrl
	import lbbc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.new_get)
						state_d = ST_SCAN_RD;
					else if (sts.new_oob)
						state_d = ST_DONE;
					else
						state_d = ST_SLOT_RD;
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (sts.hit_now)
					state_d = ST_DONE;
				else if (sts.last_rank)
					state_d = ST_VICTIM;
				else
					state_d = ST_SCAN_RD;
			end
			ST_VICTIM:   state_d = ST_DONE;
			ST_SLOT_RD:  state_d = ST_SLOT_UPD;
			ST_SLOT_UPD: state_d = sts.rel_zero ? ST_MRU : ST_DONE;
			ST_MRU: begin
				if (sts.mru_end)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_SCAN_RD:  cmd.scan_read = 1'b1;
			ST_SCAN_CHK: cmd.scan_check = 1'b1;
			ST_VICTIM:   cmd.victim_commit = 1'b1;
			ST_SLOT_RD:  cmd.slot_read = 1'b1;
			ST_SLOT_UPD: cmd.slot_update = 1'b1;
			ST_MRU:      cmd.mru_step = 1'b1;
			ST_DONE:     cmd.out_load = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/lbbc_dpath.sv
// tag store, recency list and result registers of the lru block buffer cache
`default_nettype none
module lbbc_dpath
	import lbbc_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  device,
	input  wire logic [31:0] block_number,
	input  wire logic [3:0]  slot_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       slot_out,
	output logic [1:0]       status,
	output logic             hit,
	output logic             read_request,
	output logic             write_request
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam logic [SW-1:0] LAST_RANK = SW'(SLOT_COUNT - 1);

	// order_q[r] is the slot at recency rank r, rank 0 most recent
	logic [SW-1:0] order_q [SLOT_COUNT];
	entry_t mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] written_q;
	entry_t rd_q;
	logic rd_ok_q;

	logic [1:0] func_q;
	logic [7:0] dev_q;
	logic [31:0] blk_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] rank_q, cur_q, vic_q, carry_q;
	logic vic_found_q;

	logic [3:0] res_slot_q;
	logic [1:0] res_status_q;
	logic res_hit_q, res_rd_q, res_wr_q;
	logic out_valid_q;

	entry_t e, wr_data;
	logic wr_en, rd_en, match, eligible;
	logic [SW-1:0] wr_addr, rd_addr, order_at_rank;

	assign order_at_rank = order_q[rank_q];
	// never-written entries read as the reset tag
	assign e = rd_ok_q ? rd_q : '0;
	assign match = (e.dev == dev_q) && (e.blk == blk_q);
	assign eligible = (e.refs == 8'd0) && !e.dirty;

	assign rd_en = cmd.scan_read || cmd.slot_read;
	assign rd_addr = cmd.scan_read ? order_at_rank : slot_q;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q;
		wr_data = e;
		if (cmd.scan_check && match) begin
			wr_en = 1'b1;
			if (e.refs != REFS_MAX)
				wr_data.refs = e.refs + 8'd1;
		end else if (cmd.victim_commit && vic_found_q) begin
			wr_en = 1'b1;
			wr_addr = vic_q;
			wr_data = '{dev: dev_q, blk: blk_q, refs: 8'd1, valid: 1'b0, dirty: 1'b0};
		end else if (cmd.slot_update) begin
			unique case (func_t'(func_q))
				FUNC_WRITE: begin
					wr_en = 1'b1;
					wr_data.dirty = 1'b1;
				end
				FUNC_RELEASE: begin
					wr_en = (e.refs != 8'd0);
					wr_data.refs = e.refs - 8'd1;
				end
				FUNC_DISK_DONE: begin
					wr_en = 1'b1;
					wr_data.valid = 1'b1;
					wr_data.dirty = 1'b0;
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_q <= 1'b0;
			for (int r = 0; r < SLOT_COUNT; r++)
				order_q[r] <= SW'(SLOT_COUNT - 1 - r);
		end else begin
			if (wr_en)
				written_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_ok_q <= written_q[rd_addr];
			// shift the list down one place until the released slot is reached
			if (cmd.mru_step)
				order_q[rank_q] <= carry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			dev_q <= device;
			blk_q <= block_number;
			slot_q <= SW'(slot_in);
			carry_q <= SW'(slot_in);
			rank_q <= '0;
			vic_found_q <= 1'b0;
			res_slot_q <= (func_t'(func) == FUNC_GET) ? 4'd0 : slot_in;
			res_status_q <= STATUS_OK;
			res_hit_q <= 1'b0;
			res_rd_q <= 1'b0;
			res_wr_q <= 1'b0;
		end
		if (cmd.scan_read)
			cur_q <= order_at_rank;
		if (cmd.slot_read)
			cur_q <= slot_q;
		if (cmd.scan_check) begin
			rank_q <= rank_q + 1'b1;
			if (match) begin
				res_slot_q <= 4'(cur_q);
				res_hit_q <= 1'b1;
				res_rd_q <= !e.valid;
			end else if (eligible) begin
				// last eligible slot in the walk is the least recent one
				vic_q <= cur_q;
				vic_found_q <= 1'b1;
			end
		end
		if (cmd.victim_commit) begin
			if (vic_found_q) begin
				res_slot_q <= 4'(vic_q);
				res_rd_q <= 1'b1;
			end else begin
				res_status_q <= STATUS_NO_BUF;
			end
		end
		if (cmd.slot_update) begin
			if (func_t'(func_q) == FUNC_WRITE)
				res_wr_q <= 1'b1;
			if (func_t'(func_q) == FUNC_RELEASE && e.refs == 8'd0)
				res_status_q <= STATUS_REL_ERR;
		end
		if (cmd.mru_step) begin
			carry_q <= order_at_rank;
			rank_q <= rank_q + 1'b1;
		end
		if (cmd.out_load) begin
			slot_out <= res_slot_q;
			status <= res_status_q;
			hit <= res_hit_q;
			read_request <= res_rd_q;
			write_request <= res_wr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.new_get = (func_t'(func) == FUNC_GET);
		sts.new_oob = ({28'd0, slot_in} >= 32'(SLOT_COUNT));
		sts.hit_now = match;
		sts.last_rank = (rank_q == LAST_RANK);
		sts.rel_zero = (func_t'(func_q) == FUNC_RELEASE) && (e.refs == 8'd1);
		sts.mru_end = (order_at_rank == slot_q);
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire

### rtl/core/lru_block_buffer_cache.sv
// top level of the lru block buffer cache tag manager
`default_nettype none
// Tag manager for a fully associative buffer cache of SLOT_COUNT slots, one
// request at a time. A get walks the recency list from most to least recent,
// reading each slot through the registered tag store, and stops at the
// first hit; a miss walks all slots and then claims the least recent clean,
// unreferenced slot. A release that drops the count to zero also walks the
// ranks to move the slot to the front. The result sits in an output register,
// so a new request is taken while it waits.
module lru_block_buffer_cache
	import lbbc_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  device,
	input  wire logic [31:0] block_number,
	input  wire logic [3:0]  slot_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       slot_out,
	output logic [1:0]       status,
	output logic             hit,
	output logic             read_request,
	output logic             write_request
);

	cmd_t cmd;
	sts_t sts;

	lbbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbbc_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.device        (device),
		.block_number  (block_number),
		.slot_in       (slot_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.slot_out      (slot_out),
		.status        (status),
		.hit           (hit),
		.read_request  (read_request),
		.write_request (write_request)
	);

	// one request in flight: busy right after a transfer in
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_NO_BUF |-> !hit && !read_request && slot_out == 4'd0)
		else $error("no-buffer result carries a grant");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> status == STATUS_OK && !write_request)
		else $error("hit with bad status");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result lost on load");

endmodule
`default_nettype wire
